### src/smtp_reply_line_checker_defines.svh
// Assertion macros for the SMTP reply line checker.
`ifndef SMTP_REPLY_LINE_CHECKER_DEFINES_SVH
`define SMTP_REPLY_LINE_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define SRLC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("smtp reply line checker assertion failed");
`define SRLC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("smtp reply line checker assertion failed");
`else
`define SRLC_ASSERT(label, clk, rst_n, prop)
`define SRLC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

### src/smtp_rlc_pkg.sv
`timescale 1ns / 1ps

package smtp_rlc_pkg;

    localparam logic [9:0] DEFAULT_LINES = 10'd64;
    localparam logic [9:0] CODE_MIN      = 10'd100;
    localparam logic [9:0] CODE_MAX      = 10'd599;
    localparam logic [2:0] POS_SEP       = 3'd3;
    localparam logic [2:0] POS_TEXT      = 3'd4;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_HYPHEN   = 8'h2D;
    localparam logic [7:0] CHAR_TAB      = 8'h09;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_MALFORMED  = 3'd1,
        ST_CONTROL    = 3'd2,
        ST_LINE_LIMIT = 3'd3,
        ST_CODE_CHG   = 3'd4,
        ST_DONE       = 3'd5
    } status_t;

    // Summary of one complete line, valid on its last byte.
    typedef struct packed {
        logic       well;
        logic [9:0] code;
        logic       hyphen;
        logic       control;
    } line_sum_t;

    typedef struct packed {
        logic [9:0] lines_taken;
        logic       reply_done;
        logic       continued;
        logic [9:0] reply_code;
        status_t    status;
    } result_t;

endpackage

### src/smtp_rlc_line.sv
`timescale 1ns / 1ps

module smtp_rlc_line
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              line_byte,
    input  logic                    end_of_line,
    input  logic                    new_reply,
    output smtp_rlc_pkg::line_sum_t sum
);
    import smtp_rlc_pkg::*;

    logic [2:0] pos_reg, pos_next;
    logic [9:0] acc_reg, acc_next;
    logic       sep_reg, sep_next;
    logic       bad_reg, bad_next;
    logic       ctl_reg, ctl_next;

    logic [2:0] pos_cur;
    logic [9:0] acc_cur;
    logic       sep_cur, bad_cur, ctl_cur;
    logic       is_digit;

    always_comb
    begin
        // A new reply restarts the line scan before this byte.
        pos_cur = new_reply ? 3'd0 : pos_reg;
        acc_cur = new_reply ? 10'd0 : acc_reg;
        sep_cur = new_reply ? 1'b0 : sep_reg;
        bad_cur = new_reply ? 1'b0 : bad_reg;
        ctl_cur = new_reply ? 1'b0 : ctl_reg;

        is_digit = line_byte inside {[8'h30:8'h39]};

        pos_next = pos_cur;
        acc_next = acc_cur;
        sep_next = sep_cur;
        bad_next = bad_cur;
        ctl_next = ctl_cur;

        if (pos_cur < POS_SEP)
        begin
            if (is_digit)
                acc_next = (acc_cur << 3) + (acc_cur << 1) + {6'd0, line_byte[3:0]};
            else
                bad_next = 1'b1;
            if (pos_cur == 3'd2 && (acc_next < CODE_MIN || acc_next > CODE_MAX))
                bad_next = 1'b1;
        end
        else if (pos_cur == POS_SEP)
        begin
            if (line_byte == CHAR_HYPHEN)
                sep_next = 1'b1;
            else if (line_byte != CHAR_SPACE)
                bad_next = 1'b1;
        end
        else
        begin
            if (line_byte < CHAR_SPACE && line_byte != CHAR_TAB)
                ctl_next = 1'b1;
        end

        if (pos_cur < POS_TEXT)
            pos_next = pos_cur + 3'd1;

        sum.well    = !(bad_next || pos_next < POS_TEXT);
        sum.code    = sum.well ? acc_next : 10'd0;
        sum.hyphen  = sum.well && sep_next;
        sum.control = ctl_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
            acc_reg <= 10'd0;
            sep_reg <= 1'b0;
            bad_reg <= 1'b0;
            ctl_reg <= 1'b0;
        end
        else if (step)
        begin
            if (end_of_line)
            begin
                pos_reg <= 3'd0;
                acc_reg <= 10'd0;
                sep_reg <= 1'b0;
                bad_reg <= 1'b0;
                ctl_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                acc_reg <= acc_next;
                sep_reg <= sep_next;
                bad_reg <= bad_next;
                ctl_reg <= ctl_next;
            end
        end
    end

endmodule

### src/smtp_rlc_reply.sv
`timescale 1ns / 1ps

module smtp_rlc_reply
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    end_of_line,
    input  logic                    new_reply,
    input  logic [9:0]              line_limit,
    input  smtp_rlc_pkg::line_sum_t sum,
    output smtp_rlc_pkg::result_t   result
);
    import smtp_rlc_pkg::*;

    logic [9:0] code_reg, code_next;
    logic       started_reg, started_next;
    logic       finished_reg, finished_next;
    logic [9:0] count_reg, count_next;

    logic [9:0] code_cur, count_cur, limit;
    logic       started_cur, finished_cur;
    status_t    status;

    always_comb
    begin
        code_cur     = new_reply ? 10'd0 : code_reg;
        started_cur  = new_reply ? 1'b0 : started_reg;
        finished_cur = new_reply ? 1'b0 : finished_reg;
        count_cur    = new_reply ? 10'd0 : count_reg;
        limit        = (line_limit != 10'd0) ? line_limit : DEFAULT_LINES;

        // Checks in priority order; a lowered limit can leave the count above it.
        if (finished_cur)
            status = ST_DONE;
        else if (count_cur > limit)
            status = ST_LINE_LIMIT;
        else if (!sum.well)
            status = ST_MALFORMED;
        else if (sum.control)
            status = ST_CONTROL;
        else if (count_cur == limit)
            status = ST_LINE_LIMIT;
        else if (started_cur && sum.code != code_cur)
            status = ST_CODE_CHG;
        else
            status = ST_OK;

        code_next     = code_cur;
        started_next  = started_cur;
        finished_next = finished_cur;
        count_next    = count_cur;
        if (status == ST_OK)
        begin
            if (!started_cur)
            begin
                code_next    = sum.code;
                started_next = 1'b1;
            end
            count_next    = count_cur + 10'd1;
            finished_next = !sum.hyphen;
        end

        result.status      = status;
        result.reply_code  = sum.code;
        result.continued   = sum.hyphen;
        result.reply_done  = finished_next;
        result.lines_taken = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg     <= 10'd0;
            started_reg  <= 1'b0;
            finished_reg <= 1'b0;
            count_reg    <= 10'd0;
        end
        else if (step && (end_of_line || new_reply))
        begin
            code_reg     <= end_of_line ? code_next : 10'd0;
            started_reg  <= end_of_line && started_next;
            finished_reg <= end_of_line && finished_next;
            count_reg    <= end_of_line ? count_next : 10'd0;
        end
    end

endmodule

### src/smtp_reply_line_checker.sv
`timescale 1ns / 1ps
// Channel   Dir  Fields (low bit first)
// s_*       in   tdata: line_byte[7:0]; tlast: end_of_line; tuser: new_reply
// m_*       out  tdata: status[2:0], reply_code[12:3], continued[13],
//                reply_done[14], lines_taken[24:15], zero[31:25]
// cfg_*     in   cfg_wr_data: line_limit[9:0]
//
// One byte per cycle while no result is stalled. A byte is held in the input register,
// then the line scan and reply check run in one pass into the result register.
// m_tvalid rises when a last byte moves from the input register into the result register.
// Reset clears the line and reply state and sets the line limit to the default.
// A stalled result holds only bytes that end a line; other bytes keep flowing.

`include "smtp_reply_line_checker_defines.svh"

module smtp_reply_line_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // line_byte
    input  logic        s_tlast,    // end_of_line
    input  logic        s_tuser,    // new_reply
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // status, reply_code, continued, reply_done, lines_taken
    input  logic        cfg_wr_en,
    input  logic [9:0]  cfg_wr_data // line_limit
);
    import smtp_rlc_pkg::*;

    logic [9:0] limit_reg;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eol_reg;
    logic       in_fresh_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;

    logic       out_load;
    logic       step;
    line_sum_t  sum;
    result_t    result;

    assign out_load = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && (!in_eol_reg || out_load);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= 10'd0;
        else if (cfg_wr_en)
            limit_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_eol_reg   <= s_tlast;
            in_fresh_reg <= s_tuser;
        end
    end

    smtp_rlc_line u_line
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .line_byte   (in_byte_reg),
        .end_of_line (in_eol_reg),
        .new_reply   (in_fresh_reg),
        .sum         (sum)
    );

    smtp_rlc_reply u_reply
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .end_of_line (in_eol_reg),
        .new_reply   (in_fresh_reg),
        .line_limit  (limit_reg),
        .sum         (sum),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= step && in_eol_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step && in_eol_reg)
            out_data_reg <= result;
    end

    // A line end taken into the scan always produces a result next cycle.
    `SRLC_ASSERT(a_eol_gives_result, clk, rst_n, step && in_eol_reg |=> out_valid_reg)
    // An accepted line carries a code in range.
    `SRLC_ASSERT(a_ok_code_range, clk, rst_n,
        out_valid_reg && out_data_reg.status == ST_OK |->
        out_data_reg.reply_code >= CODE_MIN && out_data_reg.reply_code <= CODE_MAX)
    // A malformed line reports neither code nor continuation.
    `SRLC_ASSERT(a_malformed_empty, clk, rst_n,
        out_valid_reg && out_data_reg.status == ST_MALFORMED |->
        out_data_reg.reply_code == 10'd0 && !out_data_reg.continued)
    // An accepted line finishes the reply exactly when it has no hyphen.
    `SRLC_ASSERT(a_ok_done_flag, clk, rst_n,
        out_valid_reg && out_data_reg.status == ST_OK |->
        out_data_reg.reply_done != out_data_reg.continued)

endmodule

### sim/smtp_reply_line_checker_tb.sv
`timescale 1ns / 1ps

module smtp_reply_line_checker_tb;
    import smtp_rlc_pkg::*;

    localparam int         CYCLE_LIMIT    = 200000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam int         PHASE_BYTES    = 140;
    localparam logic [2:0] POS_LAST_DIGIT = 3'd2;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_LF        = 8'h0A;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_DEL       = 8'h7F;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_LOWER_X   = 8'h78;

    typedef enum int {
        FAULT_DIGIT,
        FAULT_RANGE,
        FAULT_SEP,
        FAULT_SHORT,
        FAULT_CONTROL,
        FAULT_CODE,
        FAULT_NOISE
    } line_fault_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wr_en;
    logic [9:0]  cfg_wr_data;

    // Line scan and reply state of the predictor.
    logic [2:0]  scan_pos      = '0;
    logic [9:0]  scan_code     = '0;
    logic        scan_hyphen   = 1'b0;
    logic        scan_bad      = 1'b0;
    logic        scan_ctrl     = 1'b0;
    logic [9:0]  held_code     = '0;
    logic        reply_open    = 1'b0;
    logic        reply_closed  = 1'b0;
    logic [9:0]  accepted_lines = '0;
    logic [9:0]  limit_copy    = '0;

    result_t     pending_line_results[$];
    logic [7:0]  line_buf[$];

    int error_count   = 0;
    int results_seen  = 0;
    int cycle_count   = 0;
    int bytes_sent    = 0;
    bit idle_on       = 1'b1;

    smtp_reply_line_checker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !idle_on || ($urandom_range(99) >= 34);
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch at result %0d: %s", $time, results_seen, what);
    endtask

    task automatic clear_line_scan();
        scan_pos    = '0;
        scan_code   = '0;
        scan_hyphen = 1'b0;
        scan_bad    = 1'b0;
        scan_ctrl   = 1'b0;
    endtask

    task automatic scan_reply_byte(input logic [7:0] b, input logic eol, input logic fresh);
        result_t    r;
        logic [9:0] lim;
        if (fresh)
        begin
            clear_line_scan();
            held_code      = '0;
            reply_open     = 1'b0;
            reply_closed   = 1'b0;
            accepted_lines = '0;
        end
        if (scan_pos < POS_SEP)
        begin
            if (b < CHAR_ZERO || b > CHAR_NINE)
                scan_bad = 1'b1;
            else
                scan_code = scan_code * 10'd10 + {2'b00, b - CHAR_ZERO};
            if (scan_pos == POS_LAST_DIGIT && (scan_code < CODE_MIN || scan_code > CODE_MAX))
                scan_bad = 1'b1;
        end
        else if (scan_pos == POS_SEP)
        begin
            if (b == CHAR_HYPHEN)
                scan_hyphen = 1'b1;
            else if (b != CHAR_SPACE)
                scan_bad = 1'b1;
        end
        else if (b < CHAR_SPACE && b != CHAR_TAB)
        begin
            scan_ctrl = 1'b1;
        end
        if (scan_pos < POS_TEXT)
            scan_pos = scan_pos + 3'd1;
        if (eol)
        begin
            if (scan_pos < POS_TEXT)
                scan_bad = 1'b1;
            r.reply_code = scan_bad ? 10'd0 : scan_code;
            r.continued  = !scan_bad && scan_hyphen;
            lim = (limit_copy == '0) ? DEFAULT_LINES : limit_copy;
            // A limit lowered below the running count is reported before line faults.
            if (reply_closed)
                r.status = ST_DONE;
            else if (accepted_lines > lim)
                r.status = ST_LINE_LIMIT;
            else if (scan_bad)
                r.status = ST_MALFORMED;
            else if (scan_ctrl)
                r.status = ST_CONTROL;
            else if (accepted_lines == lim)
                r.status = ST_LINE_LIMIT;
            else if (reply_open && r.reply_code != held_code)
                r.status = ST_CODE_CHG;
            else
                r.status = ST_OK;
            if (r.status == ST_OK)
            begin
                if (!reply_open)
                begin
                    held_code  = r.reply_code;
                    reply_open = 1'b1;
                end
                accepted_lines = accepted_lines + 10'd1;
                reply_closed   = !r.continued;
            end
            r.reply_done  = reply_closed;
            r.lines_taken = accepted_lines;
            pending_line_results.push_back(r);
            clear_line_scan();
        end
    endtask

    // Results are checked before the byte taken on the same edge is predicted.
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = m_tdata[24:0];
            if (pending_line_results.size() == 0)
            begin
                report_mismatch($sformatf("result %h with none expected", m_tdata));
            end
            else
            begin
                want = pending_line_results.pop_front();
                if (seen.status != want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              seen.status, want.status));
                if (seen.reply_code != want.reply_code)
                    report_mismatch($sformatf("reply_code %0d, expected %0d",
                                              seen.reply_code, want.reply_code));
                if (seen.continued != want.continued)
                    report_mismatch($sformatf("continued %0d, expected %0d",
                                              seen.continued, want.continued));
                if (seen.reply_done != want.reply_done)
                    report_mismatch($sformatf("reply_done %0d, expected %0d",
                                              seen.reply_done, want.reply_done));
                if (seen.lines_taken != want.lines_taken)
                    report_mismatch($sformatf("lines_taken %0d, expected %0d",
                                              seen.lines_taken, want.lines_taken));
            end
            results_seen++;
        end
        if (rst_n && s_tvalid && s_tready)
            scan_reply_byte(s_tdata, s_tlast, s_tuser);
    end

    // Each call ends at the edge where the byte transaction completed.
    task automatic send_byte(input logic [7:0] b, input logic eol, input logic fresh);
        while (idle_on && $urandom_range(99) < 34)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        s_tuser  <= fresh;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_line(input bit fresh, input bit stray_fresh);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1,
                      (i == 0) ? fresh : (stray_fresh && $urandom_range(199) == 0));
    endtask

    task automatic build_line(input int code, input bit hyphen, input int text_len);
        int sel;
        line_buf.delete();
        line_buf.push_back(CHAR_ZERO + 8'(code / 100 % 10));
        line_buf.push_back(CHAR_ZERO + 8'(code / 10 % 10));
        line_buf.push_back(CHAR_ZERO + 8'(code % 10));
        line_buf.push_back(hyphen ? CHAR_HYPHEN : CHAR_SPACE);
        for (int i = 0; i < text_len; i++)
        begin
            sel = $urandom_range(9);
            if (sel == 0)
                line_buf.push_back(CHAR_TAB);
            else if (sel == 1)
                line_buf.push_back(8'($urandom_range(255, 127)));
            else
                line_buf.push_back(8'($urandom_range(126, 32)));
        end
    endtask

    // Stops the sender until every expected result is out and the block is quiet.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_line_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_limit(input logic [9:0] value);
        wait_for_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        limit_copy = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_well_formed_lines();
        build_line(100, 1'b0, 0);
        send_line(1'b1, 1'b0);
        build_line(599, 1'b1, 0);
        line_buf.push_back(CHAR_TAB);
        line_buf.push_back(CHAR_DEL);
        line_buf.push_back(8'hFF);
        line_buf.push_back(CHAR_SPACE);
        send_line(1'b1, 1'b0);
        build_line(599, 1'b0, 0);
        line_buf.push_back(8'h80);
        send_line(1'b0, 1'b0);
        build_line(250, 1'b0, 6);
        send_line(1'b1, 1'b0);
    endtask

    task automatic test_malformed_lines();
        // New reply and end of line on one byte make a one-byte line.
        send_byte(CHAR_ZERO + 8'd2, 1'b1, 1'b1);
        build_line(250, 1'b0, 0);
        line_buf = line_buf[0:1];
        send_line(1'b1, 1'b0);
        build_line(250, 1'b0, 0);
        line_buf = line_buf[0:2];
        send_line(1'b1, 1'b0);
        build_line(250, 1'b0, 3);
        line_buf[1] = CHAR_UPPER_A;
        send_line(1'b1, 1'b0);
        build_line(99, 1'b0, 0);
        send_line(1'b1, 1'b0);
        build_line(600, 1'b0, 1);
        send_line(1'b1, 1'b0);
        build_line(0, 1'b0, 0);
        send_line(1'b1, 1'b0);
        build_line(999, 1'b0, 0);
        send_line(1'b1, 1'b0);
        build_line(250, 1'b0, 2);
        line_buf[3] = CHAR_LOWER_X;
        send_line(1'b1, 1'b0);
        // A bad code and a control byte together: the format fault wins.
        build_line(99, 1'b0, 0);
        line_buf.push_back(CHAR_NUL);
        send_line(1'b1, 1'b0);
    endtask

    task automatic test_control_bytes();
        logic [7:0] ctrl[5];
        ctrl = '{CHAR_NUL, CHAR_CR, CHAR_LF, 8'h1F, 8'h01};
        foreach (ctrl[i])
        begin
            build_line(250, 1'b0, 2);
            line_buf.push_back(ctrl[i]);
            send_line(1'b1, 1'b0);
        end
    endtask

    task automatic test_reply_sequencing();
        build_line(354, 1'b1, 1);
        send_line(1'b1, 1'b0);
        build_line(354, 1'b1, 2);
        send_line(1'b0, 1'b0);
        build_line(354, 1'b0, 1);
        line_buf.push_back(CHAR_CR);
        send_line(1'b0, 1'b0);
        build_line(451, 1'b0, 1);
        send_line(1'b0, 1'b0);
        build_line(354, 1'b0, 1);
        send_line(1'b0, 1'b0);
        build_line(354, 1'b0, 1);
        send_line(1'b0, 1'b0);
        // A new reply raised in the middle of a line restarts the scan there.
        build_line(250, 1'b1, 3);
        for (int i = 0; i < line_buf.size(); i++)
            send_byte(line_buf[i], i == line_buf.size() - 1, i == 2);
    endtask

    task automatic test_line_limits();
        write_line_limit(10'd1);
        build_line(221, 1'b1, 0);
        send_line(1'b1, 1'b0);
        build_line(221, 1'b0, 0);
        send_line(1'b0, 1'b0);
        write_line_limit(10'd0);
        for (int i = 0; i < 5; i++)
        begin
            build_line(250, 1'b1, 1);
            send_line(i == 0, 1'b0);
        end
        // Limit lowered below the running count while the reply is open.
        write_line_limit(10'd2);
        build_line(250, 1'b1, 1);
        send_line(1'b0, 1'b0);
        send_byte(CHAR_ZERO + 8'd2, 1'b1, 1'b0);
        write_line_limit(10'd1023);
        build_line(250, 1'b0, 1);
        send_line(1'b0, 1'b0);
    endtask

    task automatic run_random_reply();
        int          n;
        int          code;
        int          line_code;
        int          eff;
        int          keep;
        bit          faulty;
        line_fault_t fault;
        logic [7:0]  b;
        eff = (limit_copy == '0) ? int'(DEFAULT_LINES) : int'(limit_copy);
        n = ($urandom_range(7) == 0 && eff < 80) ? eff + 2 : $urandom_range(5, 1);
        code = $urandom_range(599, 100);
        for (int i = 0; i < n; i++)
        begin
            line_code = code;
            faulty = ($urandom_range(99) < 12);
            fault = line_fault_t'($urandom_range(int'(FAULT_NOISE)));
            if (faulty && fault == FAULT_CODE)
                line_code = $urandom_range(599, 100);
            if (faulty && fault == FAULT_RANGE)
                line_code = $urandom_range(1) ? $urandom_range(99) : $urandom_range(999, 600);
            build_line(line_code, i != n - 1, $urandom_range(8));
            if (faulty)
            begin
                case (fault)
                    FAULT_DIGIT:
                    begin
                        b = 8'($urandom_range(255));
                        if (b >= CHAR_ZERO && b <= CHAR_NINE)
                            b = b + 8'h10;
                        line_buf[$urandom_range(2)] = b;
                    end
                    FAULT_SEP:
                        line_buf[3] = 8'($urandom_range(255));
                    FAULT_SHORT:
                    begin
                        keep = $urandom_range(3, 1);
                        while (line_buf.size() > keep)
                            void'(line_buf.pop_back());
                    end
                    FAULT_CONTROL:
                    begin
                        case ($urandom_range(3))
                            0: b = CHAR_NUL;
                            1: b = CHAR_CR;
                            2: b = CHAR_LF;
                            default:
                            begin
                                b = 8'($urandom_range(31, 1));
                                if (b == CHAR_TAB)
                                    b = 8'h1F;
                            end
                        endcase
                        if (line_buf.size() > 4)
                            line_buf[$urandom_range(line_buf.size() - 1, 4)] = b;
                        else
                            line_buf.push_back(b);
                    end
                    FAULT_NOISE:
                        line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
                    default:
                        ;
                endcase
            end
            send_line((i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(49) == 0), 1'b1);
        end
        // Now and then a line arrives after the reply has already ended.
        if ($urandom_range(4) == 0)
        begin
            build_line(code, 1'b0, $urandom_range(4));
            send_line(1'b0, 1'b1);
        end
    endtask

    task automatic test_random_traffic();
        logic [9:0] phase_limit[6];
        int         start;
        phase_limit = '{10'd0, 10'd1023, 10'd1, 10'd3, 10'($urandom_range(40, 2)), 10'd0};
        for (int p = 0; p < 6; p++)
        begin
            write_line_limit(phase_limit[p]);
            // One phase runs with both sides streaming back to back.
            idle_on = (p != 2);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
            begin
                if ($urandom_range(9) == 0)
                begin
                    repeat ($urandom_range(12, 1))
                        send_byte(8'($urandom_range(255)), $urandom_range(3) == 0,
                                  $urandom_range(7) == 0);
                end
                else
                begin
                    run_random_reply();
                end
                if ($urandom_range(39) == 0)
                    wait_for_results();
            end
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        s_tuser     <= 1'b0;
        m_tready    <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_well_formed_lines();
        test_malformed_lines();
        test_control_bytes();
        test_reply_sequencing();
        test_line_limits();
        test_random_traffic();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
